// File: sv/assert_macros.svh
// Assertion macros shared by the telemetry parser RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define TFP_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("tfp assertion failed");

// condition must never be true outside reset
`define TFP_NEVER(name, clk, rst_n, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("tfp forbidden condition seen");

`endif

// File: sv/tfp_pkg.sv
// Shared types, character codes and tag strings of the telemetry parser.
// No dependencies.
package tfp_pkg;

	localparam int MAX_FRAME_CHARS = 49;

	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_NUL    = 8'h00;

	// tag strings, first character in the low byte
	localparam int TEMP_TAG_LEN = 5;
	localparam logic [8*TEMP_TAG_LEN-1:0] TEMP_TAG = 40'h3A_50_4D_45_54;
	localparam int HUM_TAG_LEN = 4;
	localparam logic [8*HUM_TAG_LEN-1:0] HUM_TAG = 32'h3A_4D_55_48;

	typedef enum logic [3:0] {
		PH_SEEK   = 4'b0001,
		PH_SPACE  = 4'b0010,
		PH_DIGITS = 4'b0100,
		PH_DONE   = 4'b1000
	} tfp_phase_t;

	typedef struct packed {
		logic clear;
		logic feed;
	} tfp_ctrl_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

endpackage

// File: sv/tfp_tag_parser.sv
// One tag matcher with its atoi-style number reader, modulo 256.
// Depends on tfp_pkg.
module tfp_tag_parser #(
	parameter int TagLen = tfp_pkg::HUM_TAG_LEN,
	parameter logic [8*TagLen-1:0] TagChars = tfp_pkg::HUM_TAG
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tfp_pkg::tfp_ctrl_t ctrl,
	input  logic [7:0]         c,
	output logic               found,
	output logic [7:0]         value
);

	localparam int ProgW = (TagLen > 1) ? $clog2(TagLen) : 1;

	logic [ProgW-1:0]    prog_q, prog_d;
	tfp_pkg::tfp_phase_t phase_q, phase_d;
	logic [7:0]          acc_q, acc_d;
	logic                neg_q, neg_d;
	logic [ProgW:0]      k_next;
	logic [7:0]          digit;
	logic [7:0]          exp_ch;

	assign exp_ch = TagChars[8*prog_q +: 8];
	assign digit  = c - tfp_pkg::CH_ZERO;

	always_comb begin
		prog_d  = prog_q;
		phase_d = phase_q;
		acc_d   = acc_q;
		neg_d   = neg_q;
		k_next  = '0;
		unique case (phase_q)
			tfp_pkg::PH_SEEK: begin
				if (c == exp_ch) begin
					k_next = {1'b0, prog_q} + (ProgW+1)'(1);
				end else begin
					k_next = (ProgW+1)'(c == TagChars[7:0]);
				end
				if (k_next == (ProgW+1)'(TagLen)) begin
					phase_d = tfp_pkg::PH_SPACE;
					prog_d  = '0;
				end else begin
					prog_d = k_next[ProgW-1:0];
				end
			end
			tfp_pkg::PH_SPACE: begin
				if (tfp_pkg::is_space(c)) begin
					phase_d = tfp_pkg::PH_SPACE;
				end else if (c == tfp_pkg::CH_PLUS) begin
					phase_d = tfp_pkg::PH_DIGITS;
				end else if (c == tfp_pkg::CH_MINUS) begin
					neg_d   = 1'b1;
					phase_d = tfp_pkg::PH_DIGITS;
				end else if (tfp_pkg::is_digit(c)) begin
					acc_d   = digit;
					phase_d = tfp_pkg::PH_DIGITS;
				end else begin
					phase_d = tfp_pkg::PH_DONE;
				end
			end
			tfp_pkg::PH_DIGITS: begin
				if (tfp_pkg::is_digit(c)) begin
					acc_d = {acc_q[4:0], 3'b000} + {acc_q[6:0], 1'b0} + digit;
				end else begin
					phase_d = tfp_pkg::PH_DONE;
				end
			end
			tfp_pkg::PH_DONE: begin
				phase_d = tfp_pkg::PH_DONE;
			end
			default: begin
				phase_d = tfp_pkg::PH_SEEK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_q  <= '0;
			phase_q <= tfp_pkg::PH_SEEK;
			acc_q   <= '0;
			neg_q   <= 1'b0;
		end else if (ctrl.clear) begin
			prog_q  <= '0;
			phase_q <= tfp_pkg::PH_SEEK;
			acc_q   <= '0;
			neg_q   <= 1'b0;
		end else if (ctrl.feed) begin
			prog_q  <= prog_d;
			phase_q <= phase_d;
			acc_q   <= acc_d;
			neg_q   <= neg_d;
		end
	end

	assign found = (phase_q != tfp_pkg::PH_SEEK);
	assign value = neg_q ? (8'd0 - acc_q) : acc_q;

endmodule

// File: sv/framed_ascii_telemetry_parser.sv
// A '#' beat in the input register sets the result register when output is free.
// Throughput: one byte beat per cycle; stalls only while a result waits and the
// next '#' has reached the input register.
// arst_n clears the frame state, the stored values and both valid flags to zero.
// Depends on tfp_pkg, tfp_tag_parser and assert_macros.svh.
`include "assert_macros.svh"

module framed_ascii_telemetry_parser #(
	parameter int MaxFrameChars = tfp_pkg::MAX_FRAME_CHARS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_char,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] temperature,
	output logic [7:0] humidity,
	output logic       updated
);

	localparam int CountW = $clog2(MaxFrameChars + 1);

	logic               valid_s1;
	logic [7:0]         char_s1;
	logic               out_valid_q;
	logic [7:0]         temp_q, hum_q;
	logic               updated_q;
	logic [CountW-1:0]  frame_count_q;
	logic               text_ended_q;

	logic               is_hash, is_dollar, adv, out_free, kept;
	logic               temp_found, hum_found, both_found;
	logic [7:0]         temp_val, hum_val;
	tfp_pkg::tfp_ctrl_t ctrl;

	assign is_hash   = (char_s1 == tfp_pkg::CH_HASH);
	assign is_dollar = (char_s1 == tfp_pkg::CH_DOLLAR);
	assign out_free  = !out_valid_q || out_ready;
	assign adv       = valid_s1 && (!is_hash || out_free);
	assign in_ready  = !valid_s1 || adv;

	assign kept       = adv && !is_hash && !is_dollar
		&& (frame_count_q < CountW'(MaxFrameChars));
	assign ctrl.clear = adv && (is_hash || is_dollar);
	assign ctrl.feed  = kept && !text_ended_q && (char_s1 != tfp_pkg::CH_NUL);
	assign both_found = temp_found && hum_found;

	tfp_tag_parser #(
		.TagLen   (tfp_pkg::TEMP_TAG_LEN),
		.TagChars (tfp_pkg::TEMP_TAG)
	) u_temp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.c      (char_s1),
		.found  (temp_found),
		.value  (temp_val)
	);

	tfp_tag_parser #(
		.TagLen   (tfp_pkg::HUM_TAG_LEN),
		.TagChars (tfp_pkg::HUM_TAG)
	) u_hum (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.c      (char_s1),
		.found  (hum_found),
		.value  (hum_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			char_s1  <= '0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
			char_s1  <= rx_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= '0;
			text_ended_q  <= 1'b0;
		end else if (ctrl.clear) begin
			frame_count_q <= '0;
			text_ended_q  <= 1'b0;
		end else if (kept) begin
			frame_count_q <= frame_count_q + CountW'(1);
			if (char_s1 == tfp_pkg::CH_NUL) begin
				text_ended_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			temp_q      <= '0;
			hum_q       <= '0;
			updated_q   <= 1'b0;
		end else if (adv && is_hash) begin
			out_valid_q <= 1'b1;
			updated_q   <= both_found;
			if (both_found) begin
				temp_q <= temp_val;
				hum_q  <= hum_val;
			end
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign temperature = temp_q;
	assign humidity    = hum_q;
	assign updated     = updated_q;

	`TFP_ASSERT(a_hash_gives_result, clk, arst_n, (adv && is_hash) |=> out_valid_q)
	`TFP_ASSERT(a_stall_only_when_full, clk, arst_n, !in_ready |-> (valid_s1 && out_valid_q))
	`TFP_NEVER(a_count_in_range, clk, arst_n, frame_count_q > CountW'(MaxFrameChars))

endmodule

// File: sim/tb.sv
// Self-checking bench for framed_ascii_telemetry_parser: directed frames, then random ones.
// Readings are checked against directed values or a model of the tag and number parser.
// Depends on tfp_pkg and the parser RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] temp;
		logic [7:0] hum;
		logic       upd;
	} reading_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       has_want;
		reading_t   want;
	} byte_beat_t;

	typedef struct packed {
		logic [7:0] pad_ch;
		logic [5:0] pad_n;
		logic       has_want;
		reading_t   want;
	} row_meta_t;

	typedef struct packed {
		logic [2:0]          matched;
		tfp_pkg::tfp_phase_t phase;
		logic [7:0]          acc;
		logic                neg;
	} tag_track_t;

	localparam int DIR_ROWS = 18;
	localparam int RANDOM_BYTES = 1370;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] rx_char;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] temperature;
	logic [7:0] humidity;
	logic       updated;

	byte_beat_t offered;
	byte_beat_t byte_plan[$];
	reading_t   expected_readings[$];

	int failures = 0;
	int readings_checked = 0;
	int updates_seen = 0;
	int bytes_fed = 0;

	logic [5:0] frame_fill;
	logic       text_done;
	tag_track_t temp_track;
	tag_track_t hum_track;
	logic [7:0] held_temp = 8'd0;
	logic [7:0] held_hum = 8'd0;

	string dir_head [DIR_ROWS] = '{
		"#",
		"TEMP:7HUM:9#",
		"$TEMP:255 HUM:0#",
		"$TEMP:-1HUM:256#",
		"$HUM:5 TEMP#",
		"$TEMP:\011\012\013\014\015 +12HUM:-#",
		"$TEMP:xHUM:#",
		"$TEMP:5",
		"$",
		"$",
		"$$TTEMP:3HUMHUM:4 $TEMP:8HUM:+09x#",
		"",
		"TEMP:1HUM:1",
		"$#",
		"#",
		"$TEMP:99999HUM:-300#",
		"TEMP:5$HUM:6#",
		"$"
	};
	string dir_tail [DIR_ROWS] = '{
		"", "", "", "", "", "", "", "HUM:6#", "TEMP:1HUM:2#", "TEMP:3HUM:4#",
		"", "$TEMP:128HUM:99#", "", "", "", "", "", "TEMP:12HUM:34#"
	};
	row_meta_t dir_meta [DIR_ROWS] = '{
		{8'h00, 6'd0, 1'b1, 8'd0, 8'd0, 1'b0},
		{8'h00, 6'd0, 1'b1, 8'd7, 8'd9, 1'b1},
		{8'h00, 6'd0, 1'b1, 8'd255, 8'd0, 1'b1},
		{8'h00, 6'd0, 1'b1, 8'd255, 8'd0, 1'b1},
		{8'h00, 6'd0, 1'b0, 8'd0, 8'd0, 1'b0},
		{8'h00, 6'd0, 1'b0, 8'd0, 8'd0, 1'b0},
		{8'h00, 6'd0, 1'b0, 8'd0, 8'd0, 1'b0},
		{tfp_pkg::CH_NUL, 6'd1, 1'b0, 8'd0, 8'd0, 1'b0},
		{8'h61, 6'd38, 1'b0, 8'd0, 8'd0, 1'b0},
		{8'h61, 6'd45, 1'b0, 8'd0, 8'd0, 1'b0},
		{8'h00, 6'd0, 1'b0, 8'd0, 8'd0, 1'b0},
		{8'hFF, 6'd2, 1'b0, 8'd0, 8'd0, 1'b0},
		{8'h00, 6'd0, 1'b0, 8'd0, 8'd0, 1'b0},
		{8'h00, 6'd0, 1'b0, 8'd0, 8'd0, 1'b0},
		{8'h00, 6'd0, 1'b0, 8'd0, 8'd0, 1'b0},
		{8'h00, 6'd0, 1'b0, 8'd0, 8'd0, 1'b0},
		{8'h00, 6'd0, 1'b0, 8'd0, 8'd0, 1'b0},
		{8'h80, 6'd1, 1'b0, 8'd0, 8'd0, 1'b0}
	};

	assign rx_char = offered.ch;

	framed_ascii_telemetry_parser uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_char     (rx_char),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.temperature (temperature),
		.humidity    (humidity),
		.updated     (updated)
	);

	always #5 clk = ~clk;

	function automatic logic decimal_char(logic [7:0] c);
		return c >= tfp_pkg::CH_ZERO && c <= tfp_pkg::CH_NINE;
	endfunction

	function automatic tag_track_t tag_step(tag_track_t t, logic [39:0] tag, int len,
			logic [7:0] c);
		int k;
		case (t.phase)
			tfp_pkg::PH_SEEK: begin
				k = int'(t.matched);
				if (k < len && c == tag[8*k +: 8])
					k++;
				else
					k = (c == tag[7:0]) ? 1 : 0;
				if (k >= len) begin
					t.phase = tfp_pkg::PH_SPACE;
					k = 0;
				end
				t.matched = k[2:0];
			end
			tfp_pkg::PH_SPACE: begin
				if (c == tfp_pkg::CH_SPACE || (c >= tfp_pkg::CH_TAB && c <= tfp_pkg::CH_CR))
					t.phase = tfp_pkg::PH_SPACE;
				else if (c == tfp_pkg::CH_PLUS)
					t.phase = tfp_pkg::PH_DIGITS;
				else if (c == tfp_pkg::CH_MINUS) begin
					t.neg = 1'b1;
					t.phase = tfp_pkg::PH_DIGITS;
				end else if (decimal_char(c)) begin
					t.acc = c - tfp_pkg::CH_ZERO;
					t.phase = tfp_pkg::PH_DIGITS;
				end else
					t.phase = tfp_pkg::PH_DONE;
			end
			tfp_pkg::PH_DIGITS: begin
				if (decimal_char(c))
					t.acc = t.acc * 8'd10 + (c - tfp_pkg::CH_ZERO);
				else
					t.phase = tfp_pkg::PH_DONE;
			end
			default: ;
		endcase
		return t;
	endfunction

	function automatic void restart_frame();
		frame_fill = '0;
		text_done = 1'b0;
		temp_track = '{3'd0, tfp_pkg::PH_SEEK, 8'd0, 1'b0};
		hum_track = '{3'd0, tfp_pkg::PH_SEEK, 8'd0, 1'b0};
	endfunction

	function automatic void track_byte(byte_beat_t b);
		reading_t r;
		if (b.ch == tfp_pkg::CH_HASH) begin
			r.upd = 1'b0;
			if (temp_track.phase != tfp_pkg::PH_SEEK && hum_track.phase != tfp_pkg::PH_SEEK) begin
				held_temp = temp_track.neg ? 8'd0 - temp_track.acc : temp_track.acc;
				held_hum = hum_track.neg ? 8'd0 - hum_track.acc : hum_track.acc;
				r.upd = 1'b1;
			end
			r.temp = held_temp;
			r.hum = held_hum;
			expected_readings.push_back(b.has_want ? b.want : r);
			restart_frame();
		end else if (b.ch == tfp_pkg::CH_DOLLAR)
			restart_frame();
		else if (frame_fill < tfp_pkg::MAX_FRAME_CHARS) begin
			frame_fill++;
			if (!text_done) begin
				if (b.ch == tfp_pkg::CH_NUL)
					text_done = 1'b1;
				else begin
					temp_track = tag_step(temp_track, 40'(tfp_pkg::TEMP_TAG),
						tfp_pkg::TEMP_TAG_LEN, b.ch);
					hum_track = tag_step(hum_track, 40'(tfp_pkg::HUM_TAG),
						tfp_pkg::HUM_TAG_LEN, b.ch);
				end
			end
		end
	endfunction

	function automatic void plan_byte(logic [7:0] c);
		byte_beat_t b;
		b = '0;
		b.ch = c;
		byte_plan.push_back(b);
	endfunction

	function automatic void plan_text(string s, int n);
		for (int i = 0; i < n; i++)
			plan_byte(s[i]);
	endfunction

	function automatic void plan_blank();
		int r;
		r = $urandom_range(0, 5);
		plan_byte(r == 5 ? tfp_pkg::CH_SPACE : tfp_pkg::CH_TAB + r[7:0]);
	endfunction

	function automatic void plan_reading(string tag);
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			plan_text(tag, $urandom_range(1, tag.len() - 1));
		else if (r == 1)
			plan_text("tEmP:", 5);
		else
			plan_text(tag, tag.len());
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) plan_blank();
		r = $urandom_range(0, 9);
		if (r == 0)
			plan_byte(tfp_pkg::CH_PLUS);
		else if (r < 3)
			plan_byte(tfp_pkg::CH_MINUS);
		repeat ($urandom_range(0, 12) == 0 ? 0 : $urandom_range(1, 5))
			plan_byte(8'(tfp_pkg::CH_ZERO + $urandom_range(0, 9)));
	endfunction

	function automatic void plan_junk();
		int r;
		repeat ($urandom_range(0, 3)) begin
			r = $urandom_range(0, 29);
			if (r == 0)
				plan_byte(tfp_pkg::CH_NUL);
			else if (r == 1)
				plan_byte(tfp_pkg::CH_DOLLAR);
			else if (r < 5)
				plan_blank();
			else
				plan_byte(8'($urandom_range(8'h3A, 8'h5A)));
		end
	endfunction

	function automatic void plan_random_frame();
		int kind;
		bit hum_first;
		kind = $urandom_range(0, 99);
		if (kind < 10) begin
			repeat ($urandom_range(1, 24)) plan_byte(8'($urandom_range(0, 255)));
			return;
		end
		if (kind >= 15)
			plan_byte(tfp_pkg::CH_DOLLAR);
		if (kind >= 94)
			repeat ($urandom_range(30, 60)) plan_byte(8'($urandom_range(8'h61, 8'h7A)));
		hum_first = 1'($urandom_range(0, 1));
		plan_junk();
		if ($urandom_range(0, 11) != 0)
			plan_reading(hum_first ? "HUM:" : "TEMP:");
		plan_junk();
		if ($urandom_range(0, 11) != 0)
			plan_reading(hum_first ? "TEMP:" : "HUM:");
		plan_junk();
		plan_byte(tfp_pkg::CH_HASH);
	endfunction

	task automatic drive_plan();
		int gap;
		bit quiet;
		quiet = 1'b0;
		while (byte_plan.size() != 0) begin
			if ($urandom_range(0, 19) == 0)
				quiet = !quiet;
			gap = quiet ? 0 : $urandom_range(0, 5);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			offered <= byte_plan.pop_front();
			in_valid <= 1'b1;
			@(posedge clk);
			while (!in_ready)
				@(posedge clk);
			@(negedge clk);
		end
		in_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			track_byte(offered);
			bytes_fed++;
		end
	end

	always @(posedge clk) begin : check_readings
		reading_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_readings.size() == 0) begin
				$error("unexpected reading: temperature %0d humidity %0d updated %0b",
					temperature, humidity, updated);
				failures++;
			end else begin
				want = expected_readings.pop_front();
				if (temperature !== want.temp) begin
					$error("temperature: expected %0d, got %0d", want.temp, temperature);
					failures++;
				end
				if (humidity !== want.hum) begin
					$error("humidity: expected %0d, got %0d", want.hum, humidity);
					failures++;
				end
				if (updated !== want.upd) begin
					$error("updated: expected %0b, got %0b", want.upd, updated);
					failures++;
				end
				readings_checked++;
				if (want.upd)
					updates_seen++;
			end
		end
	end

	initial begin : receiver
		int stall;
		bit quiet;
		bit held;
		out_ready = 1'b0;
		quiet = 1'b0;
		held = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 19) == 0)
				quiet = !quiet;
			stall = quiet ? 0 : $urandom_range(0, 5);
			// hold off long enough for the parser to back up its input
			if (!held && readings_checked >= 25) begin
				stall = 400;
				held = 1'b1;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : stimulus
		byte_beat_t last;
		int directed_bytes;
		arst_n = 1'b0;
		in_valid = 1'b0;
		offered = '0;
		restart_frame();
		for (int i = 0; i < DIR_ROWS; i++) begin
			plan_text(dir_head[i], dir_head[i].len());
			repeat (dir_meta[i].pad_n) plan_byte(dir_meta[i].pad_ch);
			plan_text(dir_tail[i], dir_tail[i].len());
			if (dir_meta[i].has_want) begin
				last = byte_plan.pop_back();
				last.has_want = 1'b1;
				last.want = dir_meta[i].want;
				byte_plan.push_back(last);
			end
		end
		directed_bytes = byte_plan.size();
		while (byte_plan.size() < directed_bytes + RANDOM_BYTES)
			plan_random_frame();
		plan_byte(tfp_pkg::CH_HASH);
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		drive_plan();
		while (expected_readings.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("Fed %0d bytes (%0d directed), checked %0d readings, %0d with fresh values.",
			bytes_fed, directed_bytes, readings_checked, updates_seen);
		$display("Covered tag matching, whitespace, signs, wrap-around, truncation and stalls.");
		if (failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

// File: files.f
+incdir+sv
sv/tfp_pkg.sv
sv/tfp_tag_parser.sv
sv/framed_ascii_telemetry_parser.sv
sim/tb.sv
